// File: hw/rtl/imuca_pkg.sv
// Shared types, constants and the arctangent table of the attitude estimator.
package imuca_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_DEPTH       = 24;
    localparam int CNT_W            = 5;
    localparam int ROOT_STEPS       = 24;

    localparam logic [16:0] ONE_Q16    = 17'd65536;
    localparam logic [16:0] CAL_WEIGHT = 17'd52429;

    // Configuration register indexes.
    localparam logic [7:0] REG_GYRO_SMOOTH = 8'd0;
    localparam logic [7:0] REG_TILT_SMOOTH = 8'd1;
    localparam logic [7:0] REG_FUSION      = 8'd2;
    localparam logic [7:0] REG_STEP_SCALE  = 8'd3;

    typedef logic signed [31:0] q16_t;

    typedef enum logic [2:0] {
        LN_IDLE, LN_SQ0, LN_SQ1, LN_ROOT, LN_ROT, LN_DONE
    } lane_state_t;

    typedef enum logic [1:0] {
        ST_IDLE, ST_TILT, ST_FUSE, ST_PUSH
    } top_state_t;

    typedef struct packed {
        logic done;
        logic zero;
    } lane_stat_t;

    // atan(2^-i) in Q16.16 degrees, rounded to nearest.
    function automatic q16_t atan_entry(input logic [CNT_W-1:0] i);
        q16_t r;
        case (i)
            5'd0:    r = 32'sd2949120;
            5'd1:    r = 32'sd1740967;
            5'd2:    r = 32'sd919879;
            5'd3:    r = 32'sd466945;
            5'd4:    r = 32'sd234379;
            5'd5:    r = 32'sd117304;
            5'd6:    r = 32'sd58666;
            5'd7:    r = 32'sd29335;
            5'd8:    r = 32'sd14668;
            5'd9:    r = 32'sd7334;
            5'd10:   r = 32'sd3667;
            5'd11:   r = 32'sd1833;
            5'd12:   r = 32'sd917;
            5'd13:   r = 32'sd458;
            5'd14:   r = 32'sd229;
            5'd15:   r = 32'sd115;
            5'd16:   r = 32'sd57;
            5'd17:   r = 32'sd29;
            5'd18:   r = 32'sd14;
            5'd19:   r = 32'sd7;
            5'd20:   r = 32'sd4;
            5'd21:   r = 32'sd2;
            5'd22:   r = 32'sd1;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

    // A weight above one acts as one.
    function automatic logic [16:0] wclamp(input logic [16:0] w);
        return (w[16] && (w[15:0] != 16'd0)) ? ONE_Q16 : w;
    endfunction

endpackage

// File: hw/rtl/imuca_tilt_lane.sv
// One tilt lane: sum of squares, bit-serial square root, then CORDIC vectoring.
module imuca_tilt_lane
    import imuca_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [16:0] num,
    input  logic signed [15:0] mag_a,
    input  logic signed [15:0] mag_b,
    output lane_stat_t         stat,
    output q16_t               angle
);

    localparam logic [CNT_W-1:0] ROT_LAST  = CNT_W'(CORDIC_STEPS - 1);
    localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);

    lane_state_t state_reg, state_next;

    logic signed [16:0] num_reg;
    logic signed [15:0] a_reg, b_reg;
    logic [31:0]        sum_reg;
    logic [47:0]        v_reg, r_reg, bit_reg;
    logic signed [27:0] x_reg, y_reg;
    q16_t               z_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic signed [31:0] sq_a, sq_b;
    logic [31:0]        sum_next;
    logic [47:0]        trial, v_step, r_step;
    logic signed [27:0] sh_x, sh_y;
    q16_t               atan_i;

    assign sq_a     = a_reg * a_reg;
    assign sq_b     = b_reg * b_reg;
    assign sum_next = sum_reg + 32'(sq_b);

    // One restoring square-root step.
    assign trial = r_reg + bit_reg;
    always_comb
    begin
        if (v_reg >= trial)
        begin
            v_step = v_reg - trial;
            r_step = (r_reg >> 1) + bit_reg;
        end
        else
        begin
            v_step = v_reg;
            r_step = r_reg >> 1;
        end
    end

    assign sh_x   = x_reg >>> cnt_reg;
    assign sh_y   = y_reg >>> cnt_reg;
    assign atan_i = atan_entry(cnt_reg);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            LN_IDLE: if (start) state_next = LN_SQ0;
            LN_SQ0:  state_next = LN_SQ1;
            LN_SQ1:  state_next = LN_ROOT;
            LN_ROOT: if (cnt_reg == ROOT_LAST) state_next = LN_ROT;
            LN_ROT:  if (cnt_reg == ROT_LAST) state_next = LN_DONE;
            LN_DONE: state_next = LN_IDLE;
            default: state_next = LN_IDLE;
        endcase
    end

    // Outputs.
    always_comb
    begin
        stat.done = (state_reg == LN_DONE);
        stat.zero = (sum_reg == 32'd0);
        angle     = z_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LN_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            LN_IDLE:
            begin
                if (start)
                begin
                    num_reg <= num;
                    a_reg   <= mag_a;
                    b_reg   <= mag_b;
                end
            end
            LN_SQ0:
            begin
                sum_reg <= 32'(sq_a);
            end
            LN_SQ1:
            begin
                sum_reg <= sum_next;
                v_reg   <= {sum_next, 16'd0};
                r_reg   <= 48'd0;
                bit_reg <= 48'd1 << 46;
                cnt_reg <= '0;
            end
            LN_ROOT:
            begin
                v_reg   <= v_step;
                r_reg   <= r_step;
                bit_reg <= bit_reg >> 2;
                if (cnt_reg == ROOT_LAST)
                begin
                    x_reg   <= 28'(signed'({1'b0, r_step[23:0]}));
                    y_reg   <= {{3{num_reg[16]}}, num_reg, 8'd0};
                    z_reg   <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                end
            end
            LN_ROT:
            begin
                if (!y_reg[27])
                begin
                    x_reg <= x_reg + sh_y;
                    y_reg <= y_reg - sh_x;
                    z_reg <= z_reg + atan_i;
                end
                else
                begin
                    x_reg <= x_reg - sh_y;
                    y_reg <= y_reg + sh_x;
                    z_reg <= z_reg - atan_i;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
            default:
            begin
            end
        endcase
    end

endmodule

// File: hw/rtl/imuca_fuse.sv
// Merging stage: calibration averages, smoothing, gyro integration, fusion.
module imuca_fuse
    import imuca_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               kind,
    input  logic signed [15:0] raw_x,
    input  logic signed [15:0] raw_y,
    input  logic signed [15:0] raw_z,
    input  q16_t               tilt_p,
    input  q16_t               tilt_r,
    input  logic [16:0]        gyro_smoothing,
    input  logic [16:0]        tilt_smoothing,
    input  logic [16:0]        fusion_weight,
    input  logic [31:0]        step_scale,
    output logic               done,
    output q16_t               pitch,
    output q16_t               roll,
    output q16_t               yaw
);

    localparam logic [3:0] RUN_LAST = 4'd10;
    localparam logic [3:0] CAL_LAST = 4'd4;

    q16_t bias_reg[3], rate_avg_reg[3], att_reg[3], cal_rate_reg[3];
    q16_t cal_tilt_reg[2], corr_reg[3], gyro_reg[3], acc_reg[2];
    logic [3:0] step_reg;
    logic       busy_reg, done_reg;

    logic signed [15:0] raw_arr[3];
    logic [1:0]         ax;
    logic               int_mode;
    logic [16:0]        w_sel;
    q16_t               fresh, old;
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] prod, rnd;
    q16_t               blend_res;
    logic signed [33:0] inc;
    logic signed [34:0] gsum;
    q16_t               gyro_new;
    q16_t               corr_new[3];

    assign raw_arr[0] = raw_x;
    assign raw_arr[1] = raw_y;
    assign raw_arr[2] = raw_z;

    // Operand selection for the shared multiplier.
    always_comb
    begin
        ax       = 2'd0;
        int_mode = 1'b0;
        w_sel    = CAL_WEIGHT;
        fresh    = '0;
        old      = '0;
        if (kind)
        begin
            case (step_reg)
                4'd1, 4'd2, 4'd3:
                begin
                    ax    = 2'(step_reg - 4'd1);
                    w_sel = wclamp(gyro_smoothing);
                    fresh = corr_reg[ax];
                    old   = rate_avg_reg[ax];
                end
                4'd4, 4'd5, 4'd6:
                begin
                    ax       = 2'(step_reg - 4'd4);
                    int_mode = 1'b1;
                end
                4'd7:
                begin
                    w_sel = wclamp(tilt_smoothing);
                    fresh = tilt_p;
                    old   = att_reg[0];
                end
                4'd8:
                begin
                    w_sel = wclamp(tilt_smoothing);
                    fresh = tilt_r;
                    old   = att_reg[1];
                end
                4'd9:
                begin
                    w_sel = wclamp(fusion_weight);
                    fresh = gyro_reg[0];
                    old   = acc_reg[0];
                end
                4'd10:
                begin
                    w_sel = wclamp(fusion_weight);
                    fresh = gyro_reg[1];
                    old   = acc_reg[1];
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            case (step_reg)
                4'd0, 4'd1, 4'd2:
                begin
                    ax    = step_reg[1:0];
                    fresh = {raw_arr[ax], 16'd0};
                    old   = cal_rate_reg[ax];
                end
                4'd3:
                begin
                    fresh = tilt_p;
                    old   = cal_tilt_reg[0];
                end
                4'd4:
                begin
                    fresh = tilt_r;
                    old   = cal_tilt_reg[1];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Blend is old + round(w*(new-old)/2^16); integration adds rate*scale/2^32.
    always_comb
    begin
        if (int_mode)
        begin
            mul_a = 33'(rate_avg_reg[ax]);
            mul_b = signed'({1'b0, step_scale});
        end
        else
        begin
            mul_a = 33'(fresh) - 33'(old);
            mul_b = signed'({16'd0, w_sel});
        end
    end

    assign prod      = mul_a * mul_b;
    assign rnd       = prod + 66'sd32768;
    assign blend_res = old + 32'(rnd >>> 16);
    assign inc       = 34'((prod + (66'sd1 <<< 31)) >>> 32);
    assign gsum      = 35'(att_reg[ax]) + 35'(inc);

    // Saturate the integrated angle.
    always_comb
    begin
        if (gsum > 35'sd2147483647)
            gyro_new = 32'sh7FFFFFFF;
        else if (gsum < -35'sd2147483648)
            gyro_new = 32'sh80000000;
        else
            gyro_new = 32'(gsum);
    end

    // Bias-corrected rates, saturated.
    always_comb
    begin
        logic signed [33:0] d;
        for (int i = 0; i < 3; i++)
        begin
            d = 34'(signed'({raw_arr[i], 16'd0})) - 34'(bias_reg[i]);
            if (d > 34'sd2147483647)
                corr_new[i] = 32'sh7FFFFFFF;
            else if (d < -34'sd2147483648)
                corr_new[i] = 32'sh80000000;
            else
                corr_new[i] = 32'(d);
        end
    end

    // Sequencer and filter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                bias_reg[i]     <= '0;
                rate_avg_reg[i] <= '0;
                att_reg[i]      <= '0;
                cal_rate_reg[i] <= '0;
            end
            cal_tilt_reg[0] <= '0;
            cal_tilt_reg[1] <= '0;
            step_reg        <= '0;
            busy_reg        <= 1'b0;
            done_reg        <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (kind)
                begin
                    case (step_reg)
                        4'd0:             corr_reg <= corr_new;
                        4'd1, 4'd2, 4'd3: rate_avg_reg[ax] <= blend_res;
                        4'd4, 4'd5, 4'd6: gyro_reg[ax] <= gyro_new;
                        4'd7:             acc_reg[0] <= blend_res;
                        4'd8:             acc_reg[1] <= blend_res;
                        4'd9:             att_reg[0] <= blend_res;
                        4'd10:
                        begin
                            att_reg[1] <= blend_res;
                            att_reg[2] <= gyro_reg[2];
                        end
                        default:
                        begin
                        end
                    endcase
                    if (step_reg == RUN_LAST)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
                else
                begin
                    case (step_reg)
                        4'd0, 4'd1, 4'd2:
                        begin
                            cal_rate_reg[ax] <= blend_res;
                            bias_reg[ax]     <= blend_res;
                        end
                        4'd3:
                        begin
                            cal_tilt_reg[0] <= blend_res;
                            att_reg[0]      <= blend_res;
                        end
                        4'd4:
                        begin
                            cal_tilt_reg[1] <= blend_res;
                            att_reg[1]      <= blend_res;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (step_reg == CAL_LAST)
                    begin
                        busy_reg <= 1'b0;
                        done_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign done  = done_reg;
    assign pitch = att_reg[0];
    assign roll  = att_reg[1];
    assign yaw   = att_reg[2];

endmodule

// File: hw/rtl/imu_complementary_attitude.sv
// Top level of the six-axis complementary-filter attitude estimator.
// One sample beat in gives one attitude beat out. Two tilt lanes (pitch and
// roll) run side by side: the squaring states SQ0 and SQ1, a bit-serial
// square root, CORDIC_STEPS vectoring iterations and a done state. The
// merging stage then steps through a calibration sample or a longer run
// sample on one shared multiplier and then reports done. When the
// accelerometer magnitude seen by either lane (hypot(ax, az) or
// hypot(ay, az)) is zero, the merging stage is skipped, the held attitude
// is returned with tilt_error and the filter state is left alone. The next
// sample can be taken in the cycle after the attitude beat is loaded into
// the output register; an attitude beat still waiting on m_tready holds off
// the following one.
module imu_complementary_attitude
    import imuca_pkg::*;
#(
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,  // accel_x, accel_y, accel_z, rate_x, rate_y, rate_z
    input  logic        s_tuser,  // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,  // pitch, roll, yaw
    output logic        m_tuser,  // tilt_error
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    top_state_t state_reg, state_next;

    logic [16:0] gyro_smooth_reg, tilt_smooth_reg, fusion_reg;
    logic [31:0] step_scale_reg;

    logic               kind_reg;
    logic signed [15:0] rx_reg, ry_reg, rz_reg;
    logic               err_reg;
    logic               out_valid_reg;
    logic [95:0]        out_data_reg;
    logic               out_err_reg;

    logic       s_accept, lane_start, fuse_start, fuse_done, push;
    lane_stat_t p_stat, r_stat;
    q16_t       p_angle, r_angle, f_pitch, f_roll, f_yaw;

    assign s_accept = s_tvalid && s_tready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_accept) state_next = ST_TILT;
            ST_TILT:
            begin
                if (p_stat.done)
                    state_next = (p_stat.zero || r_stat.zero) ? ST_PUSH : ST_FUSE;
            end
            ST_FUSE: if (fuse_done) state_next = ST_PUSH;
            ST_PUSH: if (push) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Control outputs.
    always_comb
    begin
        s_tready   = (state_reg == ST_IDLE);
        lane_start = (state_reg == ST_IDLE) && s_tvalid;
        fuse_start = (state_reg == ST_TILT) && p_stat.done
                     && !p_stat.zero && !r_stat.zero;
        push       = (state_reg == ST_PUSH) && (!out_valid_reg || m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            gyro_smooth_reg <= 17'd32768;
            tilt_smooth_reg <= 17'd32768;
            fusion_reg      <= 17'd64225;
            step_scale_reg  <= 32'd65536;
        end
        else
        begin
            state_reg <= state_next;
            if (push)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
            // Configuration writes; unknown indexes are dropped.
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_GYRO_SMOOTH: gyro_smooth_reg <= cfg_data[16:0];
                    REG_TILT_SMOOTH: tilt_smooth_reg <= cfg_data[16:0];
                    REG_FUSION:      fusion_reg      <= cfg_data[16:0];
                    REG_STEP_SCALE:  step_scale_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Sample capture, error flag and output register.
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            kind_reg <= s_tuser;
            rx_reg   <= s_tdata[63:48];
            ry_reg   <= s_tdata[79:64];
            rz_reg   <= s_tdata[95:80];
        end
        if (state_reg == ST_TILT && p_stat.done)
            err_reg <= p_stat.zero || r_stat.zero;
        if (push)
        begin
            out_data_reg <= {f_yaw, f_roll, f_pitch};
            out_err_reg  <= err_reg;
        end
    end

    // Pitch lane: atan2(ay, hypot(ax, az)); roll lane: atan2(-ax, hypot(ay, az)).
    imuca_tilt_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_pitch
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .num   (17'(signed'(s_tdata[31:16]))),
        .mag_a (s_tdata[15:0]),
        .mag_b (s_tdata[47:32]),
        .stat  (p_stat),
        .angle (p_angle)
    );

    imuca_tilt_lane #(.CORDIC_STEPS(CORDIC_STEPS)) u_lane_roll
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (lane_start),
        .num   (-17'(signed'(s_tdata[15:0]))),
        .mag_a (s_tdata[31:16]),
        .mag_b (s_tdata[47:32]),
        .stat  (r_stat),
        .angle (r_angle)
    );

    imuca_fuse u_fuse
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (fuse_start),
        .kind           (kind_reg),
        .raw_x          (rx_reg),
        .raw_y          (ry_reg),
        .raw_z          (rz_reg),
        .tilt_p         (p_angle),
        .tilt_r         (r_angle),
        .gyro_smoothing (gyro_smooth_reg),
        .tilt_smoothing (tilt_smooth_reg),
        .fusion_weight  (fusion_reg),
        .step_scale     (step_scale_reg),
        .done           (fuse_done),
        .pitch          (f_pitch),
        .roll           (f_roll),
        .yaw            (f_yaw)
    );

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign m_tuser   = out_err_reg;

endmodule
